// File: hdl/aaac_pkg.sv
`timescale 1ns / 1ps

package aaac_pkg;

    // Instruction codes carried on the mode field.
    typedef enum logic [2:0] {
        MODE_AAA      = 3'd0,
        MODE_AAS      = 3'd1,
        MODE_AAD      = 3'd2,
        MODE_AAM      = 3'd3,
        MODE_ADC_BYTE = 3'd4,
        MODE_ADC_WORD = 3'd5
    } mode_t;

    localparam logic [15:0] ADJ_WORD    = 16'h0106;
    localparam logic [7:0]  DEC_BASE    = 8'h0A;
    localparam logic [7:0]  NIBBLE_MASK = 8'b0000_1111;
    localparam logic [3:0]  NIBBLE_MAX  = 4'h9;

    // Reciprocal of ten scaled by 2^11; exact quotient for any 8-bit dividend.
    localparam logic [7:0]  RECIP_TEN   = 8'd205;
    localparam int          RECIP_SHIFT = 11;

    // Architectural state kept between instructions.
    typedef struct packed {
        logic [15:0] acc;
        logic        carry;
        logic        aux;
        logic        parity;
        logic        sign;
        logic        zero;
    } arch_state_t;

endpackage

// File: hdl/ascii_adjust_and_add_carry_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_imm_low, s_imm_high
// m_        out        m_valid / m_ready  m_ax_out, m_carry_out, m_aux_out, m_parity_out,
//                                         m_sign_out, m_zero_out, m_bad_base
//
// One instruction is accepted per cycle while s_ready is high. It executes while held in
// the input register, and its result, with the kept AX and flags, is written when it
// executes, so each result passes the input register and then the result register.
// Reset (aresetn low at a rising edge) clears AX, all flags and both valid bits.
// While the result register is held by a low m_ready, the input register still takes
// one more transfer; s_ready then falls until the result is taken.
module ascii_adjust_and_add_carry_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_imm_low,
    input  logic [7:0]  s_imm_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_ax_out,
    output logic        m_carry_out,
    output logic        m_aux_out,
    output logic        m_parity_out,
    output logic        m_sign_out,
    output logic        m_zero_out,
    output logic        m_bad_base
);

    // Input register stage.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [2:0] mode_reg;
    logic [7:0] imm_low_reg;
    logic [7:0] imm_high_reg;

    // Kept architectural state and its value after the held instruction.
    aaac_pkg::arch_state_t state_reg;
    aaac_pkg::arch_state_t state_next;
    logic                  bad_next;

    // Result register stage.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] ax_out_reg;
    logic        carry_out_reg;
    logic        aux_out_reg;
    logic        parity_out_reg;
    logic        sign_out_reg;
    logic        zero_out_reg;
    logic        bad_base_reg;

    logic s_fire;
    logic exec_fire;

    // The held instruction executes whenever the result register is free or being
    // emptied in the same cycle.
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;
    assign s_fire    = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !exec_fire);
    assign out_valid_next = exec_fire || (out_valid_reg && !m_ready);

    aaac_alu u_alu (
        .mode     (mode_reg),
        .imm_low  (imm_low_reg),
        .imm_high (imm_high_reg),
        .cur      (state_reg),
        .nxt      (state_next),
        .bad_base (bad_next)
    );

    // Control state and the kept accumulator and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg     <= s_mode;
            imm_low_reg  <= s_imm_low;
            imm_high_reg <= s_imm_high;
        end
        if (exec_fire) begin
            ax_out_reg     <= state_next.acc;
            carry_out_reg  <= state_next.carry;
            aux_out_reg    <= state_next.aux;
            parity_out_reg <= state_next.parity;
            sign_out_reg   <= state_next.sign;
            zero_out_reg   <= state_next.zero;
            bad_base_reg   <= bad_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_ax_out     = ax_out_reg;
    assign m_carry_out  = carry_out_reg;
    assign m_aux_out    = aux_out_reg;
    assign m_parity_out = parity_out_reg;
    assign m_sign_out   = sign_out_reg;
    assign m_zero_out   = zero_out_reg;
    assign m_bad_base   = bad_base_reg;

    // A pending result always mirrors the kept accumulator, since both are written
    // together and the state moves only when a new result is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ax_out == state_reg.acc) && (m_carry_out == state_reg.carry))
        else $error("pending result disagrees with the kept state");

    // A rejected base leaves the whole state untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && bad_next |=> (state_reg == $past(state_reg)))
        else $error("state changed on a bad base");

    // AAM always leaves a single decimal digit in AL.
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (mode_reg == aaac_pkg::MODE_AAM) && !bad_next
        |=> (state_reg.acc[7:0] < aaac_pkg::DEC_BASE))
        else $error("AAM remainder out of range");

    // Nothing is executed without a held instruction, and an instruction held while
    // the result side is free must execute.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |-> exec_fire)
        else $error("held instruction not executed");

endmodule

// File: hdl/aaac_alu.sv
`timescale 1ns / 1ps

// Combinational execution of one accumulator instruction on the kept state.
module aaac_alu (
    input  logic [2:0]           mode,
    input  logic [7:0]           imm_low,
    input  logic [7:0]           imm_high,
    input  aaac_pkg::arch_state_t cur,
    output aaac_pkg::arch_state_t nxt,
    output logic                 bad_base
);

    logic [7:0]  al;
    logic [7:0]  ah;
    logic        adjust;
    logic [15:0] adj_sum;
    logic [15:0] adj_diff;
    logic [7:0]  aad_al;
    logic [15:0] aam_prod;
    logic [4:0]  aam_quot;
    logic [7:0]  aam_rem;
    logic [7:0]  adcb_al;
    logic [15:0] adcw_ax;
    logic        base_ok;

    assign al       = cur.acc[7:0];
    assign ah       = cur.acc[15:8];
    assign adjust   = (al[3:0] > aaac_pkg::NIBBLE_MAX) || cur.aux;
    assign adj_sum  = cur.acc + aaac_pkg::ADJ_WORD;
    assign adj_diff = cur.acc - aaac_pkg::ADJ_WORD;
    assign base_ok  = (imm_low == aaac_pkg::DEC_BASE);

    // AH * 10 as two shifts, truncated to a byte.
    assign aad_al   = al + {ah[4:0], 3'b000} + {ah[6:0], 1'b0};

    assign aam_prod = al * aaac_pkg::RECIP_TEN;
    assign aam_quot = aam_prod[15:aaac_pkg::RECIP_SHIFT];
    assign aam_rem  = al - ({aam_quot, 3'b000} + {2'b00, aam_quot, 1'b0});

    assign adcb_al  = al + imm_low + {7'd0, cur.carry};
    assign adcw_ax  = cur.acc + {imm_high, imm_low} + {15'd0, cur.carry};

    always_comb begin
        nxt      = cur;
        bad_base = 1'b0;
        case (mode)
            aaac_pkg::MODE_AAA: begin
                nxt.acc   = adjust ? {adj_sum[15:8], adj_sum[7:0] & aaac_pkg::NIBBLE_MASK}
                                   : {ah, al & aaac_pkg::NIBBLE_MASK};
                nxt.aux   = adjust;
                nxt.carry = adjust;
            end
            aaac_pkg::MODE_AAS: begin
                nxt.acc   = adjust ? {adj_diff[15:8], adj_diff[7:0] & aaac_pkg::NIBBLE_MASK}
                                   : {ah, al & aaac_pkg::NIBBLE_MASK};
                nxt.aux   = adjust;
                nxt.carry = adjust;
            end
            aaac_pkg::MODE_AAD: begin
                if (base_ok) begin
                    nxt.acc    = {8'd0, aad_al};
                    nxt.parity = ~^aad_al;
                    nxt.sign   = aad_al[7];
                    nxt.zero   = (aad_al == 8'd0);
                end else begin
                    bad_base = 1'b1;
                end
            end
            aaac_pkg::MODE_AAM: begin
                if (base_ok) begin
                    nxt.acc    = {3'd0, aam_quot, aam_rem};
                    nxt.parity = ~^aam_rem;
                    nxt.sign   = aam_rem[7];
                    nxt.zero   = (aam_rem == 8'd0);
                end else begin
                    bad_base = 1'b1;
                end
            end
            aaac_pkg::MODE_ADC_BYTE: begin
                nxt.acc = {ah, adcb_al};
            end
            aaac_pkg::MODE_ADC_WORD: begin
                nxt.acc = adcw_ax;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule
